[hdl/oal_pkg.sv]
// Package with the shared types and request codes of the ordered array list.
package oal_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_UPDATE = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    // Input beat.
    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] position;
        logic [7:0] value;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic       error;
        logic [7:0] read_value;
        logic [4:0] list_length;
    } t_out;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOOP,
        ST_SH_RD,
        ST_SH_WR,
        ST_RD_WAIT,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;     // capture the input beat
        logic set_err;      // reject the request
        logic cur_init_ins; // cursor starts at the list end
        logic cur_init_del; // cursor starts at the position
        logic rd_shift;     // read the neighbor of the cursor
        logic wr_shift;     // write the read data at the cursor and step it
        logic wr_val;       // write the request value
        logic rd_pos;       // read the entry at the position
        logic cap_rd;       // capture the read data as result
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic out_load;     // present the result beat
    } t_oal_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] kind;      // request code of the held request
        logic       ok;        // request can be carried out
        logic       loop_more; // entries are still left to move
        logic       out_busy;  // output register holds a beat that is not being taken
    } t_oal_status;

endpackage

[hdl/oal_ctrl.sv]
// Controller state machine that sequences each request of the ordered array list.
module oal_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  oal_pkg::t_oal_status i_st,
    output oal_pkg::t_oal_cmd    o_cmd
);
    import oal_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_st.ok) begin
                    n_state = ST_FIN;
                end else begin
                    unique case (i_st.kind) inside
                        REQ_INSERT, REQ_DELETE: n_state = ST_LOOP;
                        REQ_READ:               n_state = ST_RD_WAIT;
                        default:                n_state = ST_FIN;
                    endcase
                end
            end
            ST_LOOP: begin
                n_state = i_st.loop_more ? ST_SH_RD : ST_FIN;
            end
            ST_SH_RD:   n_state = ST_SH_WR;
            ST_SH_WR:   n_state = ST_LOOP;
            ST_RD_WAIT: n_state = ST_FIN;
            ST_FIN: begin
                if (!i_st.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            ST_DECODE: begin
                if (!i_st.ok) begin
                    o_cmd.set_err = 1'b1;
                end else begin
                    unique case (i_st.kind)
                        REQ_APPEND: begin
                            o_cmd.wr_val  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                        REQ_INSERT: o_cmd.cur_init_ins = 1'b1;
                        REQ_DELETE: o_cmd.cur_init_del = 1'b1;
                        REQ_UPDATE: o_cmd.wr_val       = 1'b1;
                        REQ_READ:   o_cmd.rd_pos       = 1'b1;
                        REQ_CLEAR:  o_cmd.cnt_clr      = 1'b1;
                        default:    o_cmd.set_err      = 1'b1;
                    endcase
                end
            end
            ST_LOOP: begin
                // Once the gap is open, an insert writes its value; a delete shrinks.
                if (!i_st.loop_more) begin
                    if (i_st.kind == REQ_INSERT) begin
                        o_cmd.wr_val  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                end
            end
            ST_SH_RD:   o_cmd.rd_shift = 1'b1;
            ST_SH_WR:   o_cmd.wr_shift = 1'b1;
            ST_RD_WAIT: o_cmd.cap_rd   = 1'b1;
            ST_FIN:     o_cmd.out_load = !i_st.out_busy;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

[hdl/oal_dp.sv]
// Datapath of the ordered array list: entry memory, length, cursor and result register.
module oal_dp #(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  oal_pkg::t_in         i_in_data,
    input  oal_pkg::t_oal_cmd    i_cmd,
    output oal_pkg::t_oal_status o_st,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output oal_pkg::t_out        o_out_data
);
    import oal_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PCW = (CW > 4) ? CW : 4;
    localparam int LCW = (CW > 5) ? CW : 5;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    t_in           r_req;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_cursor;
    logic          r_err;
    logic [7:0]    r_rd;
    logic          r_out_valid;
    t_out          r_out;

    logic [PCW-1:0] pos_x;
    logic [PCW-1:0] cnt_x;
    logic [PCW-1:0] cur_x;
    logic [LCW-1:0] cnt_l;
    logic           full;
    logic           is_ins;
    logic           ok;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [7:0]     wdata;
    logic           re;
    logic [AW-1:0]  raddr;

    assign pos_x  = PCW'(r_req.position);
    assign cnt_x  = PCW'(r_count);
    assign cur_x  = PCW'(r_cursor);
    assign cnt_l  = LCW'(r_count);
    assign full   = (r_count == CW'(DEPTH));
    assign is_ins = (r_req.req_type == REQ_INSERT);

    // Whether the held request can be carried out.
    always_comb begin
        case (r_req.req_type) inside
            REQ_APPEND:                    ok = !full;
            REQ_INSERT:                    ok = !full && (pos_x <= cnt_x);
            REQ_DELETE, REQ_UPDATE,
            REQ_READ:                      ok = (pos_x < cnt_x);
            REQ_CLEAR:                     ok = 1'b1;
            default:                       ok = 1'b0;
        endcase
    end

    assign o_st.kind      = r_req.req_type;
    assign o_st.ok        = ok;
    assign o_st.loop_more = is_ins ? (cur_x > pos_x) : (CW'(r_cursor + 1'b1) < r_count);
    assign o_st.out_busy  = r_out_valid && !i_out_ready;

    // Memory port addresses and write data.
    always_comb begin
        we    = i_cmd.wr_val || i_cmd.wr_shift;
        wdata = i_cmd.wr_shift ? r_rdata : r_req.value;
        if (i_cmd.wr_shift) begin
            waddr = r_cursor[AW-1:0];
        end else if (r_req.req_type == REQ_APPEND) begin
            waddr = r_count[AW-1:0];
        end else begin
            waddr = pos_x[AW-1:0];
        end
        re = i_cmd.rd_pos || i_cmd.rd_shift;
        if (i_cmd.rd_shift) begin
            raddr = is_ins ? AW'(r_cursor - 1'b1) : AW'(r_cursor + 1'b1);
        end else begin
            raddr = pos_x[AW-1:0];
        end
    end

    // Entry memory, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // Request, cursor and partial result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_data;
            r_err <= 1'b0;
            r_rd  <= 8'd0;
        end
        if (i_cmd.set_err) begin
            r_err <= 1'b1;
        end
        if (i_cmd.cap_rd) begin
            r_rd <= r_rdata;
        end
        if (i_cmd.cur_init_ins) begin
            r_cursor <= r_count;
        end else if (i_cmd.cur_init_del) begin
            r_cursor <= pos_x[CW-1:0];
        end else if (i_cmd.wr_shift) begin
            r_cursor <= is_ins ? CW'(r_cursor - 1'b1) : CW'(r_cursor + 1'b1);
        end
    end

    // List length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= CW'(r_count + 1'b1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= CW'(r_count - 1'b1);
        end
    end

    // Output register; the next request may run while this beat waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.error       <= r_err;
            r_out.read_value  <= r_rd;
            r_out.list_length <= cnt_l[4:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/ordered_array_list.sv]
// Top level of the ordered array list.
// Keeps an ordered list of up to DEPTH byte entries in a memory (one write and
// one registered read per cycle) and answers every request beat with one result
// beat. A request is taken only when the controller is idle; append, update,
// clear and rejected requests go from decode straight to finish, and a read
// first waits for its registered memory read. Insert and delete move the later
// entries one at a time through the memory port, reading and then writing each
// moved entry. The result sits in an output register, so the next request is
// accepted and worked while an earlier result waits to be taken. No clearing
// pass is needed after reset: only entries below the length are read.
module ordered_array_list #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  oal_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output oal_pkg::t_out  o_out_data
);
    import oal_pkg::*;

    t_oal_cmd    cmd;
    t_oal_status st;

    // Request sequencing.
    oal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Storage and result.
    oal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[dv/tb.sv]
// Self-checking testbench for the ordered array list with a request predictor and checker.
module tb;

    import oal_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1400;

    // Request codes that the block has no meaning for.
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    // Predicts one result beat per request and checks the beats that come back in order.
    class list_tracker;
        logic [7:0] slots [LIST_DEPTH];
        int         entries_held;
        int         mismatches;
        t_out       replies_due [$];

        function new();
            entries_held = 0;
            mismatches   = 0;
            foreach (slots[n]) slots[n] = 8'd0;
        endfunction

        // Applies an accepted request to the shadow list and queues the reply it must give.
        function void take_request(t_in req);
            t_out rsp;
            int   n;
            rsp.error      = 1'b1;
            rsp.read_value = 8'd0;
            case (req.req_type)
                REQ_APPEND: begin
                    if (entries_held < LIST_DEPTH) begin
                        slots[entries_held] = req.value;
                        entries_held++;
                        rsp.error = 1'b0;
                    end
                end
                REQ_INSERT: begin
                    if (entries_held < LIST_DEPTH && int'(req.position) <= entries_held) begin
                        for (n = entries_held; n > int'(req.position); n--)
                            slots[n] = slots[n - 1];
                        slots[req.position] = req.value;
                        entries_held++;
                        rsp.error = 1'b0;
                    end
                end
                REQ_DELETE: begin
                    if (int'(req.position) < entries_held) begin
                        for (n = int'(req.position); n + 1 < entries_held; n++)
                            slots[n] = slots[n + 1];
                        entries_held--;
                        rsp.error = 1'b0;
                    end
                end
                REQ_UPDATE: begin
                    if (int'(req.position) < entries_held) begin
                        slots[req.position] = req.value;
                        rsp.error = 1'b0;
                    end
                end
                REQ_READ: begin
                    if (int'(req.position) < entries_held) begin
                        rsp.read_value = slots[req.position];
                        rsp.error      = 1'b0;
                    end
                end
                REQ_CLEAR: begin
                    entries_held = 0;
                    rsp.error    = 1'b0;
                end
                default: begin
                end
            endcase
            rsp.list_length = 5'(entries_held);
            replies_due.push_back(rsp);
        endfunction

        // Compares a result beat with the oldest reply still owed.
        function void check_reply(t_out got);
            t_out want;
            if (replies_due.size() == 0) begin
                $error("result beat with no request outstanding: %p", got);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            if (got.error !== want.error) begin
                $error("error: expected %0d, actual %0d", want.error, got.error);
                mismatches++;
            end
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected 0x%02h, actual 0x%02h",
                       want.read_value, got.read_value);
                mismatches++;
            end
            if (got.list_length !== want.list_length) begin
                $error("list_length: expected %0d, actual %0d",
                       want.list_length, got.list_length);
                mismatches++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    logic steady    = 1'b0;

    list_tracker lists = new();

    ordered_array_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // Clock with a period of four time units.
    initial begin
        forever #2 clk = ~clk;
    end

    // The receiver stalls in about 30 percent of cycles, except in the steady stretch.
    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 30);
    end

    // Every result beat taken is checked against the predicted reply.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            lists.check_reply(out_data);
    end

    function automatic t_in make_req(logic [2:0] kind, logic [3:0] pos, logic [7:0] val);
        t_in req;
        req.req_type = kind;
        req.position = pos;
        req.value    = val;
        return req;
    endfunction

    // Draws a request, mostly with a position that the current list length allows.
    function automatic t_in pick_request(int held, bit grow);
        t_in req;
        int  roll;
        int  top;
        roll = $urandom_range(99);
        if (roll < 3)
            req.req_type = REQ_CLEAR;
        else if (roll < 6)
            req.req_type = $urandom_range(1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
        else if (roll < (grow ? 30 : 16))
            req.req_type = REQ_APPEND;
        else if (roll < (grow ? 58 : 32))
            req.req_type = REQ_INSERT;
        else if (roll < (grow ? 72 : 66))
            req.req_type = REQ_DELETE;
        else if (roll < 84)
            req.req_type = REQ_UPDATE;
        else
            req.req_type = REQ_READ;
        req.value = 8'($urandom);
        // An insert may land one past the last entry; the others must hit an entry.
        top = (req.req_type == REQ_INSERT) ? held : held - 1;
        if (top > LIST_DEPTH - 1)
            top = LIST_DEPTH - 1;
        if (top < 0 || $urandom_range(99) < 15)
            req.position = 4'($urandom_range(LIST_DEPTH - 1));
        else
            req.position = 4'($urandom_range(top));
        return req;
    endfunction

    // Holds a request beat until it is taken, then records it and may idle a while.
    task automatic send_request(input t_in req);
        int gap;
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        lists.take_request(req);
        gap = 0;
        if (!steady && $urandom_range(99) < 30)
            gap = $urandom_range(6, 1);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stimulus, drain and verdict.
    initial begin
        int k;
        bit grow;
        grow = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reads, deletes, updates and an insert past the end are refused on an empty list, as are the unused codes.
        send_request(make_req(REQ_READ, 4'd0, 8'h00));
        send_request(make_req(REQ_DELETE, 4'd15, 8'hFF));
        send_request(make_req(REQ_UPDATE, 4'd0, 8'hFF));
        send_request(make_req(REQ_INSERT, 4'd1, 8'h5A));
        send_request(make_req(REQ_UNUSED_LO, 4'd15, 8'hFF));
        send_request(make_req(REQ_UNUSED_HI, 4'd0, 8'h00));

        // Build a short list through inserts at the front, the end and the middle.
        send_request(make_req(REQ_INSERT, 4'd0, 8'h00));
        send_request(make_req(REQ_APPEND, 4'd0, 8'hFF));
        send_request(make_req(REQ_INSERT, 4'd2, 8'h5A));
        send_request(make_req(REQ_INSERT, 4'd1, 8'hA5));
        send_request(make_req(REQ_INSERT, 4'd9, 8'h33));

        // Fill the list, then push against the full limit.
        for (k = 4; k < LIST_DEPTH; k++)
            send_request(make_req(REQ_APPEND, 4'(k), 8'(k * 17)));
        send_request(make_req(REQ_APPEND, 4'd0, 8'h77));
        send_request(make_req(REQ_INSERT, 4'd0, 8'h88));

        // Work the last slot, shift the whole list down, then empty it.
        send_request(make_req(REQ_UPDATE, 4'd15, 8'h00));
        send_request(make_req(REQ_READ, 4'd15, 8'hFF));
        send_request(make_req(REQ_DELETE, 4'd0, 8'h00));
        send_request(make_req(REQ_DELETE, 4'd14, 8'h00));
        send_request(make_req(REQ_READ, 4'd14, 8'h00));
        send_request(make_req(REQ_CLEAR, 4'd15, 8'hFF));
        send_request(make_req(REQ_READ, 4'd0, 8'h00));

        // Random requests, alternating between growing and shrinking the list.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 60 == 0)
                grow = ~grow;
            steady <= (k >= 600 && k < 800);
            send_request(pick_request(lists.entries_held, grow));
        end
        in_valid <= 1'b0;
        steady   <= 1'b0;

        // Wait for every reply, then long enough for a full-length shift to show up.
        while (lists.pending() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (lists.mismatches == 0) begin
            $display("ordered_array_list verification clean");
        end else begin
            $display("ordered_array_list verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("ordered_array_list verification failed");
        $finish;
    end

endmodule
